// ----- sv/pft_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet filter rule table package
// Shared types and constants for the controller, the datapath and the top.
// ----------------------------------------------------------------------------
package pft_pkg;

    // Command codes on the cmd field; the fourth code is unused.
    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_CHECK = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        OUT_DEFAULT_ALLOW = 3'd0,
        OUT_RULE_ALLOW    = 3'd1,
        OUT_RULE_DENY     = 3'd2,
        OUT_SANDBOX_BLOCK = 3'd3,
        OUT_ADDED         = 3'd4,
        OUT_TABLE_FULL    = 3'd5,
        OUT_CLEARED       = 3'd6
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } state_t;

    localparam logic [7:0] ANY_DIRECTION  = 8'hFF;
    localparam logic [7:0] ANY_PROTOCOL   = 8'hFF;
    localparam logic [7:0] LOOPBACK_OCTET = 8'd127;
    localparam int         TOP_OCTET_LSB  = 24;

    // One stored rule, also used to hold the packet under test.
    typedef struct packed {
        logic [7:0]  direction;
        logic [7:0]  protocol;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic        rule_action;
    } rule_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     exec_add;
        logic     exec_clear;
        logic     rd_first;
        logic     rd_next;
        logic     emit;
        logic     use_slot;
        outcome_t outcome;
    } pft_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd_code;
        logic       full;
        logic       block;
        logic       empty;
        logic       match;
        logic       deny;
        logic       last;
    } pft_status_t;

endpackage

// ----- sv/packet_filter_rule_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet filter rule table
// Five-tuple plus direction first-match filter: add, clear and newest-first rule check.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  command   start / busy           cmd, direction, protocol, addresses, ports,
//                                   rule_action
//  result    done (one-cycle beat)  verdict, outcome, hit_slot
//  config    cfg_valid / cfg_ready  cfg_data (sandbox mode)
//
//  An add or clear is decided in the execute state and its result is registered onto done.
//  A check scans the stored rules newest first and stops at the first match;
//  the single read port of the rule memory yields one rule per cycle.
//  busy is high from the cycle after the beat until the result is issued or the unused code is dropped.
//  Reset empties the table and clears sandbox mode; no clearing pass is needed.
//  The result beat cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module packet_filter_rule_table_top
#(
    parameter int MAX_RULES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [7:0]  direction,
    input  logic [7:0]  protocol,
    input  logic [31:0] source_addr,
    input  logic [31:0] dest_addr,
    input  logic [15:0] source_port,
    input  logic [15:0] dest_port,
    input  logic        rule_action,
    output logic        done,
    output logic        verdict,
    output logic [2:0]  outcome,
    output logic [3:0]  hit_slot,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import pft_pkg::*;

    pft_cmd_t    ctl_cmd;
    pft_status_t dp_status;
    rule_t       pkt;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        pkt.direction   = direction;
        pkt.protocol    = protocol;
        pkt.source_addr = source_addr;
        pkt.dest_addr   = dest_addr;
        pkt.source_port = source_port;
        pkt.dest_port   = dest_port;
        pkt.rule_action = rule_action;
    end

    pft_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (dp_status),
        .cmd    (ctl_cmd)
    );

    pft_datapath
    #(
        .MAX_RULES (MAX_RULES)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctl_cmd),
        .status    (dp_status),
        .cmd_code  (cmd),
        .pkt       (pkt),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .done      (done),
        .verdict   (verdict),
        .outcome   (outcome),
        .hit_slot  (hit_slot)
    );

endmodule

// ----- sv/pft_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet filter controller
// Sequences add, clear and check commands and the newest-first rule scan.
// ----------------------------------------------------------------------------
module pft_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pft_pkg::pft_status_t status,
    output pft_pkg::pft_cmd_t    cmd
);
    import pft_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.outcome = OUT_DEFAULT_ALLOW;
        busy       = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                unique case (status.cmd_code)
                    CMD_ADD:
                    begin
                        cmd.emit = 1'b1;
                        if (status.full)
                        begin
                            cmd.outcome = OUT_TABLE_FULL;
                        end
                        else
                        begin
                            cmd.exec_add = 1'b1;
                            cmd.outcome  = OUT_ADDED;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        cmd.exec_clear = 1'b1;
                        cmd.emit       = 1'b1;
                        cmd.outcome    = OUT_CLEARED;
                    end
                    CMD_CHECK:
                    begin
                        priority if (status.block)
                        begin
                            cmd.emit    = 1'b1;
                            cmd.outcome = OUT_SANDBOX_BLOCK;
                        end
                        else if (status.empty)
                        begin
                            cmd.emit    = 1'b1;
                            cmd.outcome = OUT_DEFAULT_ALLOW;
                        end
                        else
                        begin
                            cmd.rd_first = 1'b1;
                            state_next   = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        // The unused code produces no result.
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN:
            begin
                priority if (status.match)
                begin
                    cmd.emit     = 1'b1;
                    cmd.use_slot = 1'b1;
                    cmd.outcome  = status.deny ? OUT_RULE_DENY : OUT_RULE_ALLOW;
                    state_next   = ST_IDLE;
                end
                else if (status.last)
                begin
                    cmd.emit    = 1'b1;
                    cmd.outcome = OUT_DEFAULT_ALLOW;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A result always returns the controller to idle.
    a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> state_reg == ST_IDLE)
        else $error("controller did not return to idle after a result");

    // The scan only ever steps while a rule read is outstanding.
    a_scan_source: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> $past(cmd.rd_first) || $past(cmd.rd_next))
        else $error("scan state entered without a rule read");

endmodule

// ----- sv/pft_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet filter datapath
// Rule memory, rule count, packet register, rule compare and result register.
// ----------------------------------------------------------------------------
module pft_datapath
#(
    parameter int MAX_RULES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pft_pkg::pft_cmd_t    cmd,
    output pft_pkg::pft_status_t status,
    input  logic [1:0]           cmd_code,
    input  pft_pkg::rule_t       pkt,
    input  logic                 cfg_valid,
    input  logic                 cfg_data,
    output logic                 done,
    output logic                 verdict,
    output logic [2:0]           outcome,
    output logic [3:0]           hit_slot
);
    import pft_pkg::*;

    localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W = $clog2(MAX_RULES + 1);

    rule_t              rule_mem [MAX_RULES];
    rule_t              pkt_reg;
    logic [1:0]         cmd_code_reg;
    logic               sandbox_reg;
    logic [CNT_W-1:0]   rule_total_reg;
    logic [CNT_W-1:0]   rule_total_next;
    logic [IDX_W-1:0]   ptr_reg;
    rule_t              rd_reg;
    logic [CNT_W-1:0]   total_m1;
    logic [IDX_W-1:0]   rd_addr;
    logic               rd_en;
    logic [IDX_W+3:0]   slot_ext;
    logic               done_reg;
    logic               verdict_reg;
    logic [2:0]         outcome_reg;
    logic [3:0]         hit_slot_reg;

    assign total_m1 = rule_total_reg - CNT_W'(1);
    assign rd_en    = cmd.rd_first || cmd.rd_next;
    assign rd_addr  = cmd.rd_first ? total_m1[IDX_W-1:0] : ptr_reg - IDX_W'(1);
    assign slot_ext = {4'b0000, ptr_reg};

    always_comb
    begin
        rule_total_next = rule_total_reg;
        if (cmd.exec_clear)
        begin
            rule_total_next = '0;
        end
        else if (cmd.exec_add)
        begin
            rule_total_next = rule_total_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_total_reg <= '0;
            sandbox_reg    <= 1'b0;
            done_reg       <= 1'b0;
            ptr_reg        <= '0;
        end
        else
        begin
            rule_total_reg <= rule_total_next;
            done_reg       <= cmd.emit;
            if (cfg_valid)
            begin
                sandbox_reg <= cfg_data;
            end
            if (rd_en)
            begin
                ptr_reg <= rd_addr;
            end
        end
    end

    // Packet and result registers carry payload only.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pkt_reg      <= pkt;
            cmd_code_reg <= cmd_code;
        end
        if (cmd.emit)
        begin
            outcome_reg  <= cmd.outcome;
            verdict_reg  <= (cmd.outcome == OUT_RULE_DENY) ||
                            (cmd.outcome == OUT_SANDBOX_BLOCK);
            hit_slot_reg <= cmd.use_slot ? slot_ext[3:0] : 4'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec_add)
        begin
            rule_mem[rule_total_reg[IDX_W-1:0]] <= pkt_reg;
        end
        if (rd_en)
        begin
            rd_reg <= rule_mem[rd_addr];
        end
    end

    always_comb
    begin
        status.cmd_code = cmd_code_reg;
        status.full     = (rule_total_reg == CNT_W'(MAX_RULES));
        status.empty    = (rule_total_reg == '0);
        status.block    = sandbox_reg &&
                          (pkt_reg.dest_addr[TOP_OCTET_LSB +: 8] != LOOPBACK_OCTET);
        status.match    = ((rd_reg.direction == pkt_reg.direction) ||
                           (rd_reg.direction == ANY_DIRECTION)) &&
                          ((rd_reg.protocol == pkt_reg.protocol) ||
                           (rd_reg.protocol == ANY_PROTOCOL)) &&
                          ((rd_reg.source_addr == pkt_reg.source_addr) ||
                           (rd_reg.source_addr == '0)) &&
                          ((rd_reg.dest_addr == pkt_reg.dest_addr) ||
                           (rd_reg.dest_addr == '0)) &&
                          ((rd_reg.source_port == pkt_reg.source_port) ||
                           (rd_reg.source_port == '0)) &&
                          ((rd_reg.dest_port == pkt_reg.dest_port) ||
                           (rd_reg.dest_port == '0));
        status.deny     = rd_reg.rule_action;
        status.last     = (ptr_reg == '0);
    end

    assign done     = done_reg;
    assign verdict  = verdict_reg;
    assign outcome  = outcome_reg;
    assign hit_slot = hit_slot_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rule_total_reg <= CNT_W'(MAX_RULES))
        else $error("rule count beyond table depth");

    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec_add |=> rule_total_reg == $past(rule_total_reg) + CNT_W'(1))
        else $error("add did not advance the rule count");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

endmodule

// ----- verif/packet_filter_rule_table_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet filter rule table testbench
// Drives add, clear, check and unused commands through the start/busy port,
// keeps its own copy of the rule table and sandbox setting, and compares
// every result beat with the predicted verdict, outcome and hit slot.
// Directed cases cover priority, wildcards, a full table and sandbox mode;
// random phases then mix well-formed rule traffic with noise.
// ----------------------------------------------------------------------------
module packet_filter_rule_table_top_tb;
    import pft_pkg::*;

    localparam int         RULE_SLOTS    = 16;
    localparam int         SETTLE_CYCLES = RULE_SLOTS + 6;
    localparam int         DRAIN_BOUND   = 2000;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;

    typedef struct packed {
        logic     verdict;
        outcome_t outcome;
        logic [3:0] hit_slot;
    } filter_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [7:0]  direction;
    logic [7:0]  protocol;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic        rule_action;
    logic        done;
    logic        verdict;
    logic [2:0]  outcome;
    logic [3:0]  hit_slot;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    // Shadow copy of the block's state.
    rule_t shadow_rules [RULE_SLOTS];
    int    shadow_count   = 0;
    logic  shadow_sandbox = 1'b0;

    filter_result_t verdict_q [$];

    int error_count = 0;
    int cycle_count = 0;
    int idle_pct    = 19;
    int n_added     = 0;
    int n_full      = 0;
    int n_checks    = 0;
    int n_hits      = 0;
    int n_blocked   = 0;
    int n_cleared   = 0;

    always #1 clk = ~clk;

    packet_filter_rule_table_top #(
        .MAX_RULES (RULE_SLOTS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .direction   (direction),
        .protocol    (protocol),
        .source_addr (source_addr),
        .dest_addr   (dest_addr),
        .source_port (source_port),
        .dest_port   (dest_port),
        .rule_action (rule_action),
        .done        (done),
        .verdict     (verdict),
        .outcome     (outcome),
        .hit_slot    (hit_slot),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    function automatic bit rule_hits(input rule_t r, input rule_t p);
        if (r.direction != ANY_DIRECTION && r.direction != p.direction) return 1'b0;
        if (r.protocol != ANY_PROTOCOL && r.protocol != p.protocol) return 1'b0;
        if (r.source_addr != 32'd0 && r.source_addr != p.source_addr) return 1'b0;
        if (r.dest_addr != 32'd0 && r.dest_addr != p.dest_addr) return 1'b0;
        if (r.source_port != 16'd0 && r.source_port != p.source_port) return 1'b0;
        if (r.dest_port != 16'd0 && r.dest_port != p.dest_port) return 1'b0;
        return 1'b1;
    endfunction

    // Applies one command to the shadow table; returns 0 when no result is due.
    function automatic bit filter_predict(input logic [1:0] c, input rule_t p,
                                          output filter_result_t res);
        int slot;
        res.verdict  = 1'b0;
        res.outcome  = OUT_DEFAULT_ALLOW;
        res.hit_slot = 4'd0;
        if (c == CMD_ADD)
        begin
            if (shadow_count >= RULE_SLOTS)
            begin
                res.outcome = OUT_TABLE_FULL;
            end
            else
            begin
                shadow_rules[shadow_count] = p;
                shadow_count++;
                res.outcome = OUT_ADDED;
            end
            return 1'b1;
        end
        if (c == CMD_CLEAR)
        begin
            shadow_count = 0;
            res.outcome  = OUT_CLEARED;
            return 1'b1;
        end
        if (c != CMD_CHECK) return 1'b0;
        if (shadow_sandbox && p.dest_addr[TOP_OCTET_LSB +: 8] != LOOPBACK_OCTET)
        begin
            res.verdict = 1'b1;
            res.outcome = OUT_SANDBOX_BLOCK;
            return 1'b1;
        end
        for (slot = shadow_count - 1; slot >= 0; slot--)
        begin
            if (rule_hits(shadow_rules[slot], p))
            begin
                res.verdict  = shadow_rules[slot].rule_action;
                res.outcome  = shadow_rules[slot].rule_action ? OUT_RULE_DENY : OUT_RULE_ALLOW;
                res.hit_slot = slot[3:0];
                return 1'b1;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_byte(input logic [7:0] common);
        case ($urandom_range(2))
            0:       return common;
            1:       return common + 8'd1;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        a = $urandom;
        case ($urandom_range(4))
            0:       a = 32'h0A00_0001;
            1:       a = 32'hFFFF_FFFF;
            2:       a[TOP_OCTET_LSB +: 8] = LOOPBACK_OCTET;
            3:       a = {LOOPBACK_OCTET, 24'h00_0001};
            default: ;
        endcase
        return a;
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(3))
            0:       return 16'd80;
            1:       return 16'd443;
            2:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bit wild();
        return $urandom_range(99) < 35;
    endfunction

    function automatic rule_t random_rule();
        rule_t r;
        r.direction   = wild() ? ANY_DIRECTION : pick_byte(8'd0);
        r.protocol    = wild() ? ANY_PROTOCOL  : pick_byte(8'd6);
        r.source_addr = wild() ? 32'd0 : pick_addr();
        r.dest_addr   = wild() ? 32'd0 : pick_addr();
        r.source_port = wild() ? 16'd0 : pick_port();
        r.dest_port   = wild() ? 16'd0 : pick_port();
        r.rule_action = 1'($urandom_range(1));
        return r;
    endfunction

    function automatic rule_t random_packet();
        rule_t p;
        p.direction   = 8'($urandom);
        p.protocol    = 8'($urandom);
        p.source_addr = $urandom;
        p.dest_addr   = $urandom;
        p.source_port = 16'($urandom);
        p.dest_port   = 16'($urandom);
        p.rule_action = 1'($urandom_range(1));
        if ($urandom_range(1)) p.dest_addr[TOP_OCTET_LSB +: 8] = LOOPBACK_OCTET;
        return p;
    endfunction

    // A packet aimed at one stored rule, sometimes nudged off it in one field.
    function automatic rule_t packet_for_rule(input rule_t r);
        rule_t p;
        p = r;
        if (r.direction == ANY_DIRECTION) p.direction = pick_byte(8'd0);
        if (r.protocol == ANY_PROTOCOL) p.protocol = pick_byte(8'd6);
        if (r.source_addr == 32'd0) p.source_addr = pick_addr();
        if (r.dest_addr == 32'd0) p.dest_addr = pick_addr();
        if (r.source_port == 16'd0) p.source_port = pick_port();
        if (r.dest_port == 16'd0) p.dest_port = pick_port();
        p.rule_action = 1'($urandom_range(1));
        if ($urandom_range(99) < 30)
        begin
            case ($urandom_range(5))
                0:       p.direction   = 8'($urandom);
                1:       p.protocol    = 8'($urandom);
                2:       p.source_addr = $urandom;
                3:       p.dest_addr   = $urandom;
                4:       p.source_port = 16'($urandom);
                default: p.dest_port   = 16'($urandom);
            endcase
        end
        return p;
    endfunction

    // Presents one command and returns at the edge that takes its beat.
    // start is left high so back-to-back commands need no gap.
    task automatic send_command(input logic [1:0] c, input rule_t p);
        filter_result_t res;
        int gap;
        if ($urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 20);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start       <= 1'b1;
        cmd         <= c;
        direction   <= p.direction;
        protocol    <= p.protocol;
        source_addr <= p.source_addr;
        dest_addr   <= p.dest_addr;
        source_port <= p.source_port;
        dest_port   <= p.dest_port;
        rule_action <= p.rule_action;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (filter_predict(c, p, res))
        begin
            verdict_q.push_back(res);
            case (res.outcome)
                OUT_ADDED:         n_added++;
                OUT_TABLE_FULL:    n_full++;
                OUT_CLEARED:       n_cleared++;
                OUT_SANDBOX_BLOCK: n_blocked++;
                OUT_RULE_ALLOW,
                OUT_RULE_DENY:     n_hits++;
                default:           ;
            endcase
            if (c == CMD_CHECK) n_checks++;
        end
    endtask

    // Stops issuing commands, waits for every expected result and lets an
    // unused command that may still be in flight run out.
    task automatic settle_block();
        int waited;
        waited = 0;
        @(negedge clk);
        start <= 1'b0;
        while (verdict_q.size() != 0 && waited < DRAIN_BOUND)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sandbox(input logic value);
        settle_block();
        repeat ($urandom_range(0, 3)) @(negedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        shadow_sandbox = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_priority_and_wildcards();
        rule_t any_deny;
        rule_t exact_allow;
        rule_t p;
        any_deny    = '{direction: ANY_DIRECTION, protocol: ANY_PROTOCOL, source_addr: 32'd0,
                        dest_addr: 32'd0, source_port: 16'd0, dest_port: 16'd0,
                        rule_action: 1'b1};
        exact_allow = '{direction: 8'd0, protocol: 8'd0, source_addr: 32'hFFFF_FFFF,
                        dest_addr: 32'hFFFF_FFFF, source_port: 16'hFFFF,
                        dest_port: 16'hFFFF, rule_action: 1'b0};
        // Empty table: default allow.
        send_command(CMD_CHECK, '0);
        send_command(CMD_ADD, any_deny);
        send_command(CMD_ADD, exact_allow);
        // The newer exact rule wins; a packet off it by direction falls to the catch-all.
        send_command(CMD_CHECK, exact_allow);
        p = exact_allow;
        p.direction = ANY_DIRECTION;
        send_command(CMD_CHECK, p);
    endtask

    task automatic test_table_full();
        repeat (RULE_SLOTS - 2) send_command(CMD_ADD, random_rule());
        send_command(CMD_ADD, random_rule());
    endtask

    task automatic test_clear_and_unused();
        send_command(CMD_CLEAR, random_packet());
        send_command(CMD_CHECK, random_packet());
        send_command(CMD_UNUSED, random_packet());
    endtask

    task automatic test_sandbox();
        rule_t p;
        write_sandbox(1'b1);
        p = random_packet();
        p.dest_addr = {LOOPBACK_OCTET, 24'hFF_FFFF};
        send_command(CMD_CHECK, p);
        p.dest_addr = {LOOPBACK_OCTET + 8'd1, 24'h00_0000};
        send_command(CMD_CHECK, p);
    endtask

    // Mostly adds and checks aimed at stored rules, with clears and unused
    // commands as noise. Unused commands do not count toward the total.
    task automatic test_random_phase(input int n_items, input logic sandbox, input int idle);
        int sent;
        int pick;
        rule_t p;
        write_sandbox(sandbox);
        idle_pct = idle;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                send_command(CMD_UNUSED, random_packet());
            end
            else
            begin
                if (pick < 7)
                begin
                    send_command(CMD_CLEAR, random_packet());
                end
                else if (pick < 45)
                begin
                    p = ($urandom_range(99) < 15) ? random_packet() : random_rule();
                    send_command(CMD_ADD, p);
                end
                else if (shadow_count > 0 && $urandom_range(99) < 70)
                begin
                    p = packet_for_rule(shadow_rules[$urandom_range(shadow_count - 1)]);
                    send_command(CMD_CHECK, p);
                end
                else
                begin
                    send_command(CMD_CHECK, random_packet());
                end
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        filter_result_t want;
        if (rst_n && done)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result beat with no command outstanding");
                error_count++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (verdict !== want.verdict)
                begin
                    $error("verdict mismatch: expected %0d, got %0d", want.verdict, verdict);
                    error_count++;
                end
                if (outcome !== want.outcome)
                begin
                    $error("outcome mismatch: expected %0d, got %0d", want.outcome, outcome);
                    error_count++;
                end
                if (hit_slot !== want.hit_slot)
                begin
                    $error("hit_slot mismatch: expected %0d, got %0d", want.hit_slot, hit_slot);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = CMD_ADD;
        direction   = 8'd0;
        protocol    = 8'd0;
        source_addr = 32'd0;
        dest_addr   = 32'd0;
        source_port = 16'd0;
        dest_port   = 16'd0;
        rule_action = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_sandbox(1'b0);
        test_priority_and_wildcards();
        test_table_full();
        test_clear_and_unused();
        test_sandbox();
        // The first random phase runs with no gaps at all.
        test_random_phase(120, 1'b0, 0);
        test_random_phase(130, 1'b1, 19);
        test_random_phase(130, 1'b0, 19);
        test_random_phase(120, 1'b1, 19);
        settle_block();

        if (verdict_q.size() != 0)
        begin
            $error("%0d expected results never arrived", verdict_q.size());
            error_count++;
        end
        $display("Covered %0d adds (%0d refused on a full table), %0d clears and %0d checks",
                 n_added, n_full, n_cleared, n_checks);
        $display("Checks gave %0d rule hits and %0d sandbox blocks across both sandbox settings",
                 n_hits, n_blocked);
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/pft_pkg.sv
sv/pft_ctrl.sv
sv/pft_datapath.sv
sv/packet_filter_rule_table_top.sv
verif/packet_filter_rule_table_top_tb.sv
